/* hw/rtl/spnt_pkg.sv */
// ----------------------------------------------------------------------------
// spnt_pkg
// Types and constants of the strip pedestal and noise tracker.
// ----------------------------------------------------------------------------
package spnt_pkg;

    localparam int CHANNELS_DEF = 256;

    localparam int PED_W   = 22;
    localparam int NOISE_W = 20;
    localparam int WGT_W   = 16;
    localparam int CM_W    = 24;

    localparam logic [PED_W-1:0]   PED_MAX   = '1;
    localparam logic [NOISE_W-1:0] NOISE_MAX = '1;
    localparam logic [NOISE_W-1:0] NOISE_ONE = NOISE_W'(65536);
    localparam logic [WGT_W-1:0]   WGT_RESET = WGT_W'(655);

    // quotient bits of the normalized deviation, bits per divider stage
    localparam int Q_W        = 18;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = Q_W / DIV_BITS;

    localparam logic CFG_PED_WEIGHT   = 1'b0;
    localparam logic CFG_NOISE_WEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0]      channel;
        logic [9:0]      sample;
        logic [CM_W-1:0] common_mode_offset;
    } in_t;

    typedef struct packed {
        logic [7:0]         out_channel;
        logic [PED_W-1:0]   pedestal;
        logic [NOISE_W-1:0] noise;
        logic               first_load;
    } out_t;

    typedef struct packed {
        logic [7:0]         ch;
        logic [PED_W-1:0]   ped;
        logic [NOISE_W-1:0] noise;
        logic               first;
        logic               blend;
    } carry_t;

endpackage

/* hw/rtl/strip_pedestal_noise_tracker_unit.sv */
// ----------------------------------------------------------------------------
// strip_pedestal_noise_tracker_unit
// Per-channel running pedestal and noise update, pipelined.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle for distinct channels while the output is
// not stalled; an item whose channel is still in flight waits until that item
// has written the channel stores. The 9-stage restoring divider for the
// normalized deviation sets the depth.
// Reset: after rst_n releases, a clearing pass of CHANNELS cycles zeroes the
// stores; in_ready stays low meanwhile. Weights reset to 655.
module strip_pedestal_noise_tracker_unit
    import spnt_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [15:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DS    = 3;                 // first divider stage
    localparam int MS    = DS + DIV_STAGES + 1; // first multiply stage
    localparam int NSTG  = MS + 2;
    localparam int NCAR  = DIV_STAGES + 3;
    localparam int REM_W = 46;

    logic [WGT_W-1:0] wp_reg, wn_reg;
    logic             clearing_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    logic [PED_W-1:0]   ped_mem   [CHANNELS];
    logic [NOISE_W-1:0] noise_mem [CHANNELS];
    logic [PED_W-1:0]   ped_rd_reg;
    logic [NOISE_W-1:0] noise_rd_reg;

    logic             v_reg   [NSTG];
    logic [IDX_W-1:0] idx_reg [NSTG];

    in_t                  in1_reg;
    carry_t               car2_reg, car3_reg;
    logic signed [23:0]   s2_reg;
    logic signed [25:0]   d2_reg;
    logic signed [40:0]   prod_reg;
    logic [25:0]          ad_reg;
    logic [21:0]          thr_reg;
    carry_t               car_reg [NCAR];
    logic [REM_W-1:0]     rem_reg [DIV_STAGES+1];
    logic [Q_W-1:0]       q_reg   [DIV_STAGES+1];
    logic [2*Q_W-1:0]     xs2_reg;
    logic [36:0]          p1_reg;
    logic [51:0]          p2_reg;
    out_t                 out_reg;
    logic                 ovalid_reg;

    logic [IDX_W-1:0] idx_lut [256];
    for (genvar i = 0; i < 256; i++) begin : g_lut
        assign idx_lut[i] = IDX_W'(i % CHANNELS);
    end

    logic             adv, hazard, accept;
    logic [IDX_W-1:0] in_idx;

    assign in_idx = idx_lut[in_data.channel];
    assign adv    = !ovalid_reg || out_ready;

    always_comb
    begin
        hazard = 1'b0;
        for (int i = 0; i < NSTG; i++)
        begin
            if (v_reg[i] && idx_reg[i] == in_idx)
                hazard = 1'b1;
        end
    end

    assign in_ready  = adv && !hazard && !clearing_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= WGT_RESET;
            wn_reg <= WGT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PED_WEIGHT:   wp_reg <= cfg_data;
                CFG_NOISE_WEIGHT: wn_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // stage 2 logic: residuals
    carry_t             car2_next;
    logic signed [23:0] s2_next;
    logic signed [25:0] d2_next;
    always_comb
    begin
        car2_next.ch    = in1_reg.channel;
        car2_next.noise = (noise_rd_reg == '0) ? NOISE_ONE : noise_rd_reg;
        car2_next.first = (ped_rd_reg == '0);
        car2_next.ped   = car2_next.first ? {in1_reg.sample, 12'b0} : ped_rd_reg;
        car2_next.blend = 1'b0;
        s2_next = $signed({2'b0, in1_reg.sample, 12'b0}) - $signed({2'b0, ped_rd_reg});
        d2_next = 26'(s2_next) - 26'($signed(in1_reg.common_mode_offset));
    end

    // stage 4 logic: pedestal correction and deviation test
    carry_t             car4_next;
    logic signed [24:0] corr;
    logic signed [13:0] corr_c;
    logic signed [25:0] np;
    always_comb
    begin
        corr = prod_reg[40:16];
        if (corr > 25'sd4096)
            corr_c = 14'sd4096;
        else if (corr < -25'sd4096)
            corr_c = -14'sd4096;
        else
            corr_c = 14'(corr);
        np = $signed({4'b0, car3_reg.ped}) + 26'(corr_c);
        car4_next = car3_reg;
        if (!car3_reg.first)
        begin
            if (np < 0)
                car4_next.ped = '0;
            else if (np > $signed({4'b0, PED_MAX}))
                car4_next.ped = PED_MAX;
            else
                car4_next.ped = np[PED_W-1:0];
        end
        car4_next.blend = !car3_reg.first &&
                          ({ad_reg, 20'b0} < {8'b0, thr_reg, 16'b0});
    end

    // divider stages
    logic [REM_W-1:0] rem_next [DIV_STAGES];
    logic [Q_W-1:0]   q_next   [DIV_STAGES];
    always_comb
    begin
        logic [REM_W-1:0] r, dv;
        logic [Q_W-1:0]   q;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            r = rem_reg[j];
            q = q_reg[j];
            for (int b = 0; b < DIV_BITS; b++)
            begin
                dv = REM_W'(car_reg[j].noise) << (Q_W - 1 - j * DIV_BITS - b);
                if (r >= dv)
                begin
                    r = r - dv;
                    q[Q_W - 1 - j * DIV_BITS - b] = 1'b1;
                end
            end
            rem_next[j] = r;
            q_next[j]   = q;
        end
    end

    // final stage: blend and saturate
    logic [53:0] acc;
    logic [21:0] nn;
    out_t        out_next;
    carry_t      car_last;
    always_comb
    begin
        car_last = car_reg[NCAR-1];
        acc = {1'b0, p1_reg, 16'b0} + {2'b0, p2_reg};
        nn  = acc[53:32];
        out_next.out_channel = car_last.ch;
        out_next.pedestal    = car_last.ped;
        out_next.first_load  = car_last.first;
        if (!car_last.blend)
            out_next.noise = car_last.noise;
        else if (nn > {2'b0, NOISE_MAX})
            out_next.noise = NOISE_MAX;
        else
            out_next.noise = nn[NOISE_W-1:0];
    end

    // control: valid bits, indexes, clearing pass, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            ovalid_reg   <= 1'b0;
            for (int i = 0; i < NSTG; i++)
            begin
                v_reg[i]   <= 1'b0;
                idx_reg[i] <= '0;
            end
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(CHANNELS - 1))
                    clearing_reg <= 1'b0;
            end
            if (adv)
            begin
                ovalid_reg <= v_reg[NSTG-1];
                v_reg[0]   <= accept;
                idx_reg[0] <= in_idx;
                for (int i = 1; i < NSTG; i++)
                begin
                    v_reg[i]   <= v_reg[i-1];
                    idx_reg[i] <= idx_reg[i-1];
                end
            end
        end
    end

    // channel stores
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            ped_mem[clr_cnt_reg]   <= '0;
            noise_mem[clr_cnt_reg] <= '0;
        end
        else if (adv && v_reg[NSTG-1])
        begin
            ped_mem[idx_reg[NSTG-1]]   <= out_next.pedestal;
            noise_mem[idx_reg[NSTG-1]] <= out_next.noise;
        end
        if (accept)
        begin
            ped_rd_reg   <= ped_mem[in_idx];
            noise_rd_reg <= noise_mem[in_idx];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in1_reg  <= in_data;
            car2_reg <= car2_next;
            s2_reg   <= s2_next;
            d2_reg   <= d2_next;

            car3_reg <= car2_reg;
            prod_reg <= 41'(s2_reg) * 41'($signed({1'b0, wp_reg}));
            ad_reg   <= d2_reg[25] ? 26'(-d2_reg) : 26'(d2_reg);
            thr_reg  <= {2'b0, car2_reg.noise} + {1'b0, car2_reg.noise, 1'b0};

            car_reg[0] <= car4_next;
            rem_reg[0] <= {ad_reg, 20'b0};
            q_reg[0]   <= '0;
            for (int j = 0; j < DIV_STAGES; j++)
            begin
                car_reg[j+1] <= car_reg[j];
                rem_reg[j+1] <= rem_next[j];
                q_reg[j+1]   <= q_next[j];
            end

            xs2_reg <= q_reg[DIV_STAGES] * q_reg[DIV_STAGES];
            car_reg[NCAR-2] <= car_reg[NCAR-3];
            p1_reg  <= 37'(car_reg[NCAR-2].noise) * 37'(17'(65536) - {1'b0, wn_reg});
            p2_reg  <= 52'(xs2_reg) * 52'(wn_reg);
            car_reg[NCAR-1] <= car_reg[NCAR-2];

            out_reg <= out_next;
        end
    end

endmodule

/* hw/rtl/spnt_checker.sv */
// ----------------------------------------------------------------------------
// spnt_checker
// Port-level checks of the strip pedestal and noise tracker.
// ----------------------------------------------------------------------------
module spnt_checker
    import spnt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_load_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.first_load |-> out_data.pedestal[11:0] == 12'b0)
        else $error("loaded pedestal has fraction bits");

    a_load_noise: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.first_load |-> out_data.noise != '0)
        else $error("zero noise on first load");

endmodule

bind strip_pedestal_noise_tracker_unit spnt_checker u_spnt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
